@@ design/bgfi_pkg.sv @@
// ----------------------------------------------------------------------------
// bgfi_pkg
// Shared types and constants of the gravity force integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package bgfi_pkg;

    // operation codes
    localparam logic [1:0] OP_GRAV  = 2'd0;
    localparam logic [1:0] OP_FORCE = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_G    = 3'd0;
    localparam logic [2:0] CFG_MASS = 3'd1;
    localparam logic [2:0] CFG_RAD  = 3'd2;
    localparam logic [2:0] CFG_X    = 3'd3;
    localparam logic [2:0] CFG_Y    = 3'd4;
    localparam logic [2:0] CFG_VX   = 3'd5;
    localparam logic [2:0] CFG_VY   = 3'd6;

    localparam int MUL_W = 33;          // multiplier operand width
    localparam int PRD_W = 2 * MUL_W;   // product width
    localparam int NUM_W = 96;          // divider dividend / quotient width
    localparam int DEN_W = 66;          // divider divisor / remainder width
    localparam int CNT_W = 7;           // divider step counter width

    localparam logic [CNT_W-1:0] STEPS_P = 7'd32;  // force magnitude quotient
    localparam logic [CNT_W-1:0] STEPS_W = 7'd64;  // 64-bit quotients

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;    // dividend, left aligned
        logic [DEN_W-1:0]  rem0;   // starting partial remainder, below den
        logic [DEN_W-1:0]  den;
        logic [CNT_W-1:0]  steps;
    } t_div_cmd;

endpackage

`default_nettype wire

@@ design/bgfi_mul.sv @@
// ----------------------------------------------------------------------------
// bgfi_mul
// Shared unsigned 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bgfi_mul
    import bgfi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [MUL_W-1:0] i_a,
    input  wire logic [MUL_W-1:0] i_b,
    output logic      [PRD_W-1:0] o_p
);

    logic [PRD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PRD_W'(i_a) * PRD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ design/bgfi_div.sv @@
// ----------------------------------------------------------------------------
// bgfi_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bgfi_div
    import bgfi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_cmd         i_cmd,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign sh   = {r_rem, r_q[NUM_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q   <= i_cmd.num;
            r_rem <= i_cmd.rem0;
            r_den <= i_cmd.den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ design/body_gravity_force_integrator.sv @@
// ----------------------------------------------------------------------------
// body_gravity_force_integrator
// One body's position and speed with gravity, force and Euler step ops.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes one beat per operation:
//  gravity from another body, apply a force, or move one step. Output
//  channel (o_out_valid / i_out_ready) returns one beat per input beat.
//  o_in_ready is high only while the sequencer is idle; one operation is
//  worked on at a time, all on one shared 33x33 multiplier and one
//  radix-2 divider.
//  Steps, input accept to output valid:
//   gravity: multiply states S_M_AX to S_P_SUM, check, force quotient
//            divide, square root (S_SQ_A, S_SQ_B per bit), component
//            multiplies, x and y component divides, final; the quotient
//            divide is skipped on a clamp; zero distance goes to final.
//   force:   x and y 64-bit divides, final; move / unused code: final.
//  Flow: the next beat is taken once the result is registered and the
//  sequencer is back in idle. If the output register is still full, the
//  result waits in the final state and body state is updated only when
//  the result moves out.
//  Reset (synchronous, active low) loads the default constants and zero
//  position/speed. Config writes are taken at once; writing a start
//  register also loads the matching position or speed.
// ----------------------------------------------------------------------------
`default_nettype none

module body_gravity_force_integrator
    import bgfi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic signed [31:0] i_other_x,
    input  wire logic signed [31:0] i_other_y,
    input  wire logic [31:0] i_other_mass,
    input  wire logic [31:0] i_other_radius,
    input  wire logic signed [31:0] i_force_x,
    input  wire logic signed [31:0] i_force_y,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic             o_collided,
    output logic             o_saturated
);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_M_AX    = 5'd1;
    localparam logic [4:0] S_M_AY    = 5'd2;
    localparam logic [4:0] S_M_RS    = 5'd3;
    localparam logic [4:0] S_M_GM    = 5'd4;
    localparam logic [4:0] S_M_PL    = 5'd5;
    localparam logic [4:0] S_M_PH    = 5'd6;
    localparam logic [4:0] S_P_SUM   = 5'd7;
    localparam logic [4:0] S_CHK     = 5'd8;
    localparam logic [4:0] S_DIV_P   = 5'd9;
    localparam logic [4:0] S_SQ_A    = 5'd10;
    localparam logic [4:0] S_SQ_B    = 5'd11;
    localparam logic [4:0] S_M_MX    = 5'd12;
    localparam logic [4:0] S_M_MY    = 5'd13;
    localparam logic [4:0] S_M_MY2   = 5'd14;
    localparam logic [4:0] S_DX_GO   = 5'd15;
    localparam logic [4:0] S_DX_WAIT = 5'd16;
    localparam logic [4:0] S_DY_GO   = 5'd17;
    localparam logic [4:0] S_DY_WAIT = 5'd18;
    localparam logic [4:0] S_FIN     = 5'd19;

    // control / config / body state
    logic [4:0]  r_state, n_state;
    logic        r_out_valid;
    logic [31:0] r_g, r_mass, r_rad;
    logic [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;

    // working registers
    logic [1:0]        r_op;
    logic [MUL_W-1:0]  r_ax, r_ay;     // |dx|,|dy| or |fx|,|fy|
    logic              r_sx, r_sy;     // signs of the above
    logic [MUL_W-1:0]  r_rsum;
    logic [31:0]       r_om;
    logic [DEN_W-1:0]  r_d2;
    logic              r_col;
    logic              r_sat;
    logic [31:0]       r_gmh;
    logic [NUM_W-1:0]  r_pp;
    logic [31:0]       r_mag;
    logic [MUL_W-1:0]  r_root;
    logic [5:0]        r_bit;
    logic [63:0]       r_nx, r_ny;
    logic [DEN_W-1:0]  r_den;
    logic [63:0]       r_qx, r_qy;
    logic [31:0]       r_rx, r_ry;
    logic              r_ocol, r_osat;

    // shared units
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PRD_W-1:0]  mul_p;
    t_div_cmd          div_cmd;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;

    bgfi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bgfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // saturating sign apply: {sat, value}
    function automatic logic [32:0] sign_sat(input logic [63:0] mag, input logic neg);
        logic [32:0] res;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) res = {1'b1, 32'h8000_0000};
            else                               res = {1'b0, 32'd0 - mag[31:0]};
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else                               res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

    // saturating signed add: {sat, value}
    function automatic logic [32:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [32:0] res;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) res = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        else                res = {1'b0, s[31:0]};
        return res;
    endfunction

    // input side
    logic        in_acc;
    logic [32:0] dx, dy;
    logic [32:0] dx_abs, dy_abs;
    logic [31:0] fx_abs, fy_abs;
    logic [31:0] mass_eff;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign dx     = {i_other_x[31], i_other_x} - {r_pos_x[31], r_pos_x};
    assign dy     = {i_other_y[31], i_other_y} - {r_pos_y[31], r_pos_y};
    assign dx_abs = dx[32] ? 33'd0 - dx : dx;
    assign dy_abs = dy[32] ? 33'd0 - dy : dy;
    assign fx_abs = i_force_x[31] ? 32'd0 - i_force_x : i_force_x;
    assign fy_abs = i_force_y[31] ? 32'd0 - i_force_y : i_force_y;
    assign mass_eff = (r_mass == 32'd0) ? 32'd1 : r_mass;

    // force magnitude overflows 32 bits
    logic p_ovf;
    assign p_ovf = ({2'b00, r_pp} >= {r_d2, 32'd0});

    // square root trial value
    logic [MUL_W-1:0] sq_c;
    assign sq_c = r_root | (MUL_W'(1) << r_bit);

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // result assembly
    logic [32:0] fx_res, fy_res, vx_new, vy_new, px_new, py_new;
    assign fx_res = sign_sat(r_qx, r_sx);
    assign fy_res = sign_sat(r_qy, r_sy);
    assign vx_new = add_sat(r_vel_x, fx_res[31:0]);
    assign vy_new = add_sat(r_vel_y, fy_res[31:0]);
    assign px_new = add_sat(r_pos_x, r_vel_x);
    assign py_new = add_sat(r_pos_y, r_vel_y);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M_AX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            S_M_AY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            S_M_RS: begin
                mul_a = r_rsum;
                mul_b = r_rsum;
            end
            S_M_GM: begin
                mul_a = {1'b0, r_g};
                mul_b = {1'b0, r_mass};
            end
            S_M_PL: begin
                mul_a = {1'b0, mul_p[31:0]};
                mul_b = {1'b0, r_om};
            end
            S_M_PH: begin
                mul_a = {1'b0, r_gmh};
                mul_b = {1'b0, r_om};
            end
            S_SQ_A: begin
                mul_a = sq_c;
                mul_b = sq_c;
            end
            S_M_MX: begin
                mul_a = {1'b0, r_mag};
                mul_b = r_ax;
            end
            S_M_MY: begin
                mul_a = {1'b0, r_mag};
                mul_b = r_ay;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider command
    always_comb begin
        div_cmd = '0;
        unique case (r_state)
            S_CHK: begin
                div_cmd.start = (r_d2 != '0) && !p_ovf;
                div_cmd.num   = {r_pp[31:0], 64'd0};
                div_cmd.rem0  = {2'b00, r_pp[95:32]};
                div_cmd.den   = r_d2;
                div_cmd.steps = STEPS_P;
            end
            S_DX_GO: begin
                div_cmd.start = 1'b1;
                div_cmd.num   = {r_nx, 32'd0};
                div_cmd.den   = r_den;
                div_cmd.steps = STEPS_W;
            end
            S_DY_GO: begin
                div_cmd.start = 1'b1;
                div_cmd.num   = {r_ny, 32'd0};
                div_cmd.den   = r_den;
                div_cmd.steps = STEPS_W;
            end
            default: div_cmd = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_operation)
                        OP_GRAV:  n_state = S_M_AX;
                        OP_FORCE: n_state = S_DX_GO;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_M_AX:  n_state = S_M_AY;
            S_M_AY:  n_state = S_M_RS;
            S_M_RS:  n_state = S_M_GM;
            S_M_GM:  n_state = S_M_PL;
            S_M_PL:  n_state = S_M_PH;
            S_M_PH:  n_state = S_P_SUM;
            S_P_SUM: n_state = S_CHK;
            S_CHK: begin
                if (r_d2 == '0) n_state = S_FIN;
                else if (p_ovf) n_state = S_SQ_A;
                else            n_state = S_DIV_P;
            end
            S_DIV_P:   n_state = div_done ? S_SQ_A : S_DIV_P;
            S_SQ_A:    n_state = S_SQ_B;
            S_SQ_B:    n_state = (r_bit == 6'd0) ? S_M_MX : S_SQ_A;
            S_M_MX:    n_state = S_M_MY;
            S_M_MY:    n_state = S_M_MY2;
            S_M_MY2:   n_state = S_DX_GO;
            S_DX_GO:   n_state = S_DX_WAIT;
            S_DX_WAIT: n_state = div_done ? S_DY_GO : S_DX_WAIT;
            S_DY_GO:   n_state = S_DY_WAIT;
            S_DY_WAIT: n_state = div_done ? S_FIN : S_DY_WAIT;
            S_FIN:     n_state = out_free ? S_IDLE : S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    // control, config and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_g         <= 32'h0001_0000;
            r_mass      <= 32'h0001_0000;
            r_rad       <= 32'd0;
            r_pos_x     <= 32'd0;
            r_pos_y     <= 32'd0;
            r_vel_x     <= 32'd0;
            r_vel_y     <= 32'd0;
        end else begin
            r_state <= n_state;
            // a new result replaces the one leaving in the same cycle
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    CFG_G:    r_g     <= i_cfg_data;
                    CFG_MASS: r_mass  <= i_cfg_data;
                    CFG_RAD:  r_rad   <= i_cfg_data;
                    CFG_X:    r_pos_x <= i_cfg_data;
                    CFG_Y:    r_pos_y <= i_cfg_data;
                    CFG_VX:   r_vel_x <= i_cfg_data;
                    CFG_VY:   r_vel_y <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                if (r_op == OP_FORCE) begin
                    r_vel_x <= vx_new[31:0];
                    r_vel_y <= vy_new[31:0];
                end else if (r_op == OP_MOVE) begin
                    r_pos_x <= px_new[31:0];
                    r_pos_y <= py_new[31:0];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_op   <= i_operation;
                    r_col  <= 1'b0;
                    r_sat  <= 1'b0;
                    r_qx   <= 64'd0;
                    r_qy   <= 64'd0;
                    r_rsum <= {1'b0, r_rad} + {1'b0, i_other_radius};
                    r_om   <= i_other_mass;
                    r_nx   <= {16'd0, fx_abs, 16'd0};
                    r_ny   <= {16'd0, fy_abs, 16'd0};
                    r_den  <= {34'd0, mass_eff};
                    if (i_operation == OP_FORCE) begin
                        r_ax <= {1'b0, fx_abs};
                        r_ay <= {1'b0, fy_abs};
                        r_sx <= i_force_x[31];
                        r_sy <= i_force_y[31];
                    end else begin
                        r_ax <= dx_abs;
                        r_ay <= dy_abs;
                        r_sx <= dx[32];
                        r_sy <= dy[32];
                    end
                end
            end
            S_M_AY:  r_d2  <= mul_p;
            S_M_RS:  r_d2  <= r_d2 + mul_p;
            S_M_GM:  r_col <= (mul_p >= r_d2);
            S_M_PL:  r_gmh <= mul_p[63:32];
            S_M_PH:  r_pp  <= {32'd0, mul_p[63:0]};
            S_P_SUM: r_pp  <= r_pp + {mul_p[63:0], 32'd0};
            S_CHK: begin
                r_root <= '0;
                r_bit  <= 6'd32;
                if (r_d2 != '0 && p_ovf) begin
                    r_mag <= 32'hFFFF_FFFF;
                    r_sat <= 1'b1;
                end
            end
            S_DIV_P: begin
                if (div_done) r_mag <= div_quot[31:0];
            end
            S_SQ_B: begin
                if (mul_p <= r_d2) r_root <= sq_c;
                if (r_bit != 6'd0) r_bit <= r_bit - 6'd1;
            end
            S_M_MX:  r_den <= {33'd0, r_root};
            S_M_MY:  r_nx  <= mul_p[63:0];
            S_M_MY2: r_ny  <= mul_p[63:0];
            S_DX_WAIT: begin
                if (div_done) r_qx <= div_quot[63:0];
            end
            S_DY_WAIT: begin
                if (div_done) r_qy <= div_quot[63:0];
            end
            S_FIN: begin
                if (out_free) begin
                    unique case (r_op)
                        OP_GRAV: begin
                            r_rx   <= fx_res[31:0];
                            r_ry   <= fy_res[31:0];
                            r_ocol <= r_col;
                            r_osat <= r_sat | fx_res[32] | fy_res[32];
                        end
                        OP_FORCE: begin
                            r_rx   <= fx_res[31:0];
                            r_ry   <= fy_res[31:0];
                            r_ocol <= 1'b0;
                            r_osat <= fx_res[32] | fy_res[32] | vx_new[32] | vy_new[32];
                        end
                        OP_MOVE: begin
                            r_rx   <= px_new[31:0];
                            r_ry   <= py_new[31:0];
                            r_ocol <= 1'b0;
                            r_osat <= px_new[32] | py_new[32];
                        end
                        default: begin
                            r_rx   <= 32'd0;
                            r_ry   <= 32'd0;
                            r_ocol <= 1'b0;
                            r_osat <= 1'b0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_result_x  = r_rx;
    assign o_result_y  = r_ry;
    assign o_collided  = r_ocol;
    assign o_saturated = r_osat;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted beat did not start the sequencer");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside final state");

    a_dx_then_dy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DX_WAIT && div_done) |=> r_state == S_DY_GO)
        else $error("y divide not started after x divide");
`endif

endmodule

`default_nettype wire
